>>> rtl/mbss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbss_pkg;

   // Signature geometry
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int WINDOW_DEPTH      = MAX_PATTERN_BYTES - 1;
   localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int POS_W             = $clog2(MAX_PATTERN_BYTES);

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HITS       = 3'd4;

   typedef logic [7:0] byte_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [63:0]      pattern_low;
      logic [63:0]      pattern_high;
      logic [15:0]      care_mask;
      logic [4:0]       pattern_length;
      logic [15:0]      max_hits;
   } cfg_type;

   // Control for one step of the scan stage
   typedef struct packed {
      logic advance;
      logic span_first;
      logic scan_first;
   } step_type;

   // Outcome of the hit gating
   typedef struct packed {
      logic        hit;
      logic [15:0] hit_index;
      logic        limit_reached;
   } hit_type;

   // Signature byte i out of the two pattern words
   function automatic byte_type sig_byte(input cfg_type cfg, input logic [POS_W-1:0] i);
      logic [127:0] pat;
      pat = {cfg.pattern_high, cfg.pattern_low};
      return pat[{i, 3'b000} +: 8];
   endfunction

endpackage

`default_nettype wire

>>> rtl/masked_byte_signature_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Wildcard byte signature scanner. Feed one memory byte per transfer with its
// offset; span_first clears the match window so hits never cross spans, and
// scan_first also restarts the hit count. A byte is registered, compared
// against all signature positions at once and, on a hit, a result carrying the
// window start offset, the hit index and the last-permitted-hit flag is
// registered for output. Throughput is one byte per clock while the result
// side keeps up; a byte passes through the input register and then the result
// register on its way to a hit. The csr port is always ready and should only be
// written while no bytes are in flight.
module masked_byte_signature_scanner_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // byte stream
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic [31:0]                        req_byte_offset,
   input  wire logic                               req_span_first,
   input  wire logic                               req_scan_first,
   // hits
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [31:0]                             rsp_match_offset,
   output logic [15:0]                             rsp_hit_index,
   output logic                                    rsp_limit_reached,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mbss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [63:0]                        csr_data
);

   mbss_pkg::cfg_type  cfg_ff;
   mbss_pkg::step_type step;
   mbss_pkg::hit_type  hit;

   logic        s_valid_ff;
   logic        s_valid_in;
   logic [7:0]  s_byte_ff;
   logic [31:0] s_offset_ff;
   logic        s_span_ff;
   logic        s_scan_ff;
   logic        req_accept;
   logic        advance;
   logic        match;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_offset_ff;
   logic [15:0] rsp_index_ff;
   logic        rsp_limit_ff;

   // Register file
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= 64'd0;
         cfg_ff.pattern_high   <= 64'd0;
         cfg_ff.care_mask      <= 16'd0;
         cfg_ff.pattern_length <= 5'd0;
         cfg_ff.max_hits       <= 16'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mbss_pkg::CSR_PATTERN_LOW:    cfg_ff.pattern_low    <= csr_data;
            mbss_pkg::CSR_PATTERN_HIGH:   cfg_ff.pattern_high   <= csr_data;
            mbss_pkg::CSR_CARE_MASK:      cfg_ff.care_mask      <= csr_data[15:0];
            mbss_pkg::CSR_PATTERN_LENGTH: cfg_ff.pattern_length <= csr_data[4:0];
            mbss_pkg::CSR_MAX_HITS:       cfg_ff.max_hits       <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Stage handshake: the byte moves on when the result slot is free or draining
   assign advance    = s_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign s_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : s_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s_byte_ff   <= req_data_byte;
         s_offset_ff <= req_byte_offset;
         s_span_ff   <= req_span_first;
         s_scan_ff   <= req_scan_first;
      end
   end

   always_comb begin
      step.advance    = advance;
      step.span_first = s_span_ff;
      step.scan_first = s_scan_ff;
   end

   mbss_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .data_byte (s_byte_ff),
      .match     (match)
   );

   mbss_hit_ctrl u_hit_ctrl (
      .clock    (clock),
      .reset    (reset),
      .max_hits (cfg_ff.max_hits),
      .step     (step),
      .match    (match),
      .result   (hit)
   );

   // Result register
   always_comb begin
      if (advance) begin
         rsp_valid_in = hit.hit;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hit.hit) begin
         // window start sits pattern_length-1 bytes back, modulo 2^32
         rsp_offset_ff <= s_offset_ff - (32'(cfg_ff.pattern_length) - 32'd1);
         rsp_index_ff  <= hit.hit_index;
         rsp_limit_ff  <= hit.limit_reached;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_offset  = rsp_offset_ff;
   assign rsp_hit_index     = rsp_index_ff;
   assign rsp_limit_reached = rsp_limit_ff;

endmodule

`default_nettype wire

>>> rtl/mbss_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

module mbss_matcher (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mbss_pkg::cfg_type  cfg,
   input  wire mbss_pkg::step_type step,
   input  wire mbss_pkg::byte_type data_byte,
   output logic                    match
);

   mbss_pkg::byte_type            window_ff [mbss_pkg::WINDOW_DEPTH];
   mbss_pkg::byte_type            hist      [mbss_pkg::MAX_PATTERN_BYTES];
   logic [mbss_pkg::LEN_W-1:0]    fill_ff;
   logic [mbss_pkg::LEN_W-1:0]    fill_in;
   logic [mbss_pkg::LEN_W-1:0]    fill_base;
   logic [mbss_pkg::LEN_W-1:0]    len;
   logic [mbss_pkg::POS_W-1:0]    idx;
   logic                          clear;

   // History seen by this byte: current byte plus cleared or stored window
   always_comb begin
      clear   = step.span_first | step.scan_first;
      hist[0] = data_byte;
      for (int k = 1; k < mbss_pkg::MAX_PATTERN_BYTES; k++) begin
         hist[k] = clear ? 8'h00 : window_ff[k-1];
      end
      fill_base = clear ? '0 : fill_ff;
      if (fill_base < mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN_BYTES)) begin
         fill_in = fill_base + 1'b1;
      end else begin
         fill_in = fill_base;
      end
   end

   // Parallel compare of every cared-for signature position
   always_comb begin
      len   = cfg.pattern_length;
      idx   = '0;
      match = (len != '0) && (len <= mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN_BYTES)) &&
              (fill_in >= len);
      for (int i = 0; i < mbss_pkg::MAX_PATTERN_BYTES; i++) begin
         // signature byte i lines up with the byte len-1-i steps ago
         idx = mbss_pkg::POS_W'(len - 1'b1 - mbss_pkg::LEN_W'(i));
         if ((mbss_pkg::LEN_W'(i) < len) && cfg.care_mask[i] &&
             (hist[idx] != mbss_pkg::sig_byte(cfg, mbss_pkg::POS_W'(i)))) begin
            match = 1'b0;
         end
      end
   end

   // Shift the current byte into the window
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mbss_pkg::WINDOW_DEPTH; k++) begin
            window_ff[k] <= 8'h00;
         end
         fill_ff <= '0;
      end else if (step.advance) begin
         for (int k = 0; k < mbss_pkg::WINDOW_DEPTH; k++) begin
            window_ff[k] <= hist[k];
         end
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/mbss_hit_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mbss_hit_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [15:0]        max_hits,
   input  wire mbss_pkg::step_type step,
   input  wire logic               match,
   output mbss_pkg::hit_type       result
);

   logic [15:0] hits_ff;
   logic [15:0] hits_in;
   logic [15:0] hits_base;
   logic [15:0] limit;

   // Gate matches by the per-scan hit budget
   always_comb begin
      hits_base            = step.scan_first ? 16'd0 : hits_ff;
      limit                = (max_hits == 16'd0) ? 16'd1 : max_hits;
      result.hit           = match && (hits_base < limit);
      result.hit_index     = hits_base;
      result.limit_reached = ({1'b0, hits_base} + 17'd1) >= {1'b0, limit};
      hits_in              = result.hit ? hits_base + 16'd1 : hits_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff <= 16'd0;
      end else if (step.advance) begin
         hits_ff <= hits_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/signature_hit_checker.sv
`timescale 1ns / 1ps

// Watches the byte stream, the hit stream and the register port of the
// scanner. Keeps its own copy of the signature registers and of the match
// window, works out the hit (if any) for every accepted byte and compares each
// hit transfer against the oldest outstanding one.
module signature_hit_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic [31:0]                    req_byte_offset,
   input  wire logic                           req_span_first,
   input  wire logic                           req_scan_first,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [31:0]                    rsp_match_offset,
   input  wire logic [15:0]                    rsp_hit_index,
   input  wire logic                           rsp_limit_reached,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [mbss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]                    csr_data,
   output int                                  mismatches,
   output int                                  pending_hits
);

   typedef struct packed {
      logic [31:0] match_offset;
      logic [15:0] hit_index;
      logic        limit_reached;
   } hit_record_type;

   // Shadow of the signature registers
   logic [63:0] sig_low;
   logic [63:0] sig_high;
   logic [15:0] sig_care;
   logic [4:0]  sig_len;
   logic [15:0] sig_max_hits;

   // Shadow of the scan state
   logic [7:0]  recent_bytes [0:mbss_pkg::WINDOW_DEPTH-1];
   int unsigned span_fill;
   int unsigned scan_hits;

   hit_record_type expected_hits [$];

   // Advance the shadow window by one byte; returns 1 and the record on a hit
   function automatic bit scan_one_byte(input logic [7:0] data, input logic [31:0] offset,
                                        input logic span_first, input logic scan_first,
                                        output hit_record_type rec);
      logic [7:0]   hist [0:mbss_pkg::MAX_PATTERN_BYTES-1];
      logic [127:0] sig;
      int unsigned  len;
      int unsigned  limit;
      bit           hit;
      len = sig_len;
      limit = (sig_max_hits == 16'd0) ? 1 : sig_max_hits;
      sig = {sig_high, sig_low};
      rec = '0;
      if (scan_first)
         scan_hits = 0;
      if (scan_first || span_first) begin
         for (int k = 0; k < mbss_pkg::WINDOW_DEPTH; k++)
            recent_bytes[k] = 8'h00;
         span_fill = 0;
      end
      // hist[k] is the byte k transfers ago
      hist[0] = data;
      for (int k = 1; k < mbss_pkg::MAX_PATTERN_BYTES; k++)
         hist[k] = recent_bytes[k-1];
      if (span_fill < mbss_pkg::MAX_PATTERN_BYTES)
         span_fill++;
      hit = len != 0 && len <= mbss_pkg::MAX_PATTERN_BYTES && span_fill >= len &&
            scan_hits < limit;
      for (int i = 0; hit && i < len; i++) begin
         if (sig_care[i] && hist[len-1-i] != sig[i*8 +: 8])
            hit = 0;
      end
      for (int k = 0; k < mbss_pkg::WINDOW_DEPTH; k++)
         recent_bytes[k] = hist[k];
      if (hit) begin
         rec.match_offset  = offset - 32'(len - 1);
         rec.hit_index     = 16'(scan_hits);
         rec.limit_reached = (scan_hits + 1 >= limit);
         scan_hits++;
      end
      return hit;
   endfunction

   always @(posedge clock) begin : monitor
      hit_record_type seen;
      hit_record_type want;
      if (reset) begin
         sig_low      = '0;
         sig_high     = '0;
         sig_care     = '0;
         sig_len      = '0;
         sig_max_hits = 16'd1;
         for (int k = 0; k < mbss_pkg::WINDOW_DEPTH; k++)
            recent_bytes[k] = 8'h00;
         span_fill = 0;
         scan_hits = 0;
         expected_hits.delete();
         mismatches = 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mbss_pkg::CSR_PATTERN_LOW:    sig_low      = csr_data;
               mbss_pkg::CSR_PATTERN_HIGH:   sig_high     = csr_data;
               mbss_pkg::CSR_CARE_MASK:      sig_care     = csr_data[15:0];
               mbss_pkg::CSR_PATTERN_LENGTH: sig_len      = csr_data[4:0];
               mbss_pkg::CSR_MAX_HITS:       sig_max_hits = csr_data[15:0];
               default: ;
            endcase
         end
         // hit transfers against the oldest outstanding hit
         if (rsp_valid && !rsp_stall) begin
            seen.match_offset  = rsp_match_offset;
            seen.hit_index     = rsp_hit_index;
            seen.limit_reached = rsp_limit_reached;
            if (expected_hits.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected hit: offset %h index %0d limit %0b",
                           $time, seen.match_offset, seen.hit_index, seen.limit_reached);
               mismatches++;
            end else begin
               want = expected_hits.pop_front();
               if (seen.match_offset !== want.match_offset ||
                   seen.hit_index !== want.hit_index ||
                   seen.limit_reached !== want.limit_reached) begin
                  if (mismatches < 10)
                     $display({"%0t: hit mismatch: expected offset %h index %0d limit %0b,",
                               " got offset %h index %0d limit %0b"},
                              $time, want.match_offset, want.hit_index, want.limit_reached,
                              seen.match_offset, seen.hit_index, seen.limit_reached);
                  mismatches++;
               end
            end
         end
         // byte transfers
         if (req_valid && !req_stall) begin
            if (scan_one_byte(req_data_byte, req_byte_offset, req_span_first,
                              req_scan_first, want))
               expected_hits.insert(expected_hits.size(), want);
         end
      end
      pending_hits = expected_hits.size();
   end

endmodule

>>> tb/sv/masked_byte_signature_scanner_core_test.sv
`timescale 1ns / 1ps

module masked_byte_signature_scanner_core_test;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 8;
   localparam int LONG_HOLD    = 300;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_data_byte = '0;
   logic [31:0]                    req_byte_offset = '0;
   logic                           req_span_first = 1'b0;
   logic                           req_scan_first = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [31:0]                    rsp_match_offset;
   logic [15:0]                    rsp_hit_index;
   logic                           rsp_limit_reached;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mbss_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]                    csr_data = '0;

   int mismatches;
   int pending_hits;

   // Idle percentages and long hold requests
   int unsigned tx_idle_pct = 13;
   int unsigned rx_idle_pct = 68;
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned cycle_count = 0;

   // Signature currently programmed, used to plant matches
   logic [63:0] sig_low;
   logic [63:0] sig_high;
   logic [15:0] sig_care;
   logic [4:0]  sig_len;

   masked_byte_signature_scanner_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_byte_offset   (req_byte_offset),
      .req_span_first    (req_span_first),
      .req_scan_first    (req_scan_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_limit_reached (rsp_limit_reached),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   signature_hit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_byte_offset   (req_byte_offset),
      .req_span_first    (req_span_first),
      .req_scan_first    (req_scan_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_match_offset  (rsp_match_offset),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_limit_reached (rsp_limit_reached),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .pending_hits      (pending_hits)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Hit sink: random stalls, plus a long hold whenever one is asked for
   initial begin : hit_sink
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            holds_served++;
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // One byte transfer, with random idle cycles in front
   task automatic send_byte(input logic [7:0] data, input logic [31:0] offset,
                            input logic span_first, input logic scan_first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_byte_offset <= offset;
      req_span_first  <= span_first;
      req_scan_first  <= scan_first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait for every outstanding hit and the pipeline to empty
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_hits != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mbss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_scanner(input logic [63:0] low, input logic [63:0] high,
                                  input logic [15:0] care, input logic [4:0] len,
                                  input logic [15:0] max_hits);
      sig_low  = low;
      sig_high = high;
      sig_care = care;
      sig_len  = len;
      write_reg(mbss_pkg::CSR_PATTERN_LOW, low);
      write_reg(mbss_pkg::CSR_PATTERN_HIGH, high);
      write_reg(mbss_pkg::CSR_CARE_MASK, {48'd0, care});
      write_reg(mbss_pkg::CSR_PATTERN_LENGTH, {59'd0, len});
      write_reg(mbss_pkg::CSR_MAX_HITS, {48'd0, max_hits});
      csr_valid <= 1'b0;
   endtask

   // Random signature setting; extremes come round regularly
   task automatic pick_setting(input int unsigned n);
      logic [15:0] care;
      logic [15:0] max_hits;
      logic [4:0]  len;
      case (n % 5)
         0:       begin len = 5'd16; care = 16'hFFFF; end
         1:       begin len = 5'd1;  care = 16'h0001; end
         2:       begin len = 5'($urandom_range(2, 15)); care = 16'h0000; end
         default: begin len = 5'($urandom_range(2, 15)); care = 16'($urandom); end
      endcase
      case (n % 4)
         0:       max_hits = 16'd1;
         1:       max_hits = 16'($urandom_range(2, 4));
         2:       max_hits = 16'hFFFF;
         default: max_hits = 16'($urandom_range(1, 40));
      endcase
      program_scanner({$urandom, $urandom}, {$urandom, $urandom}, care, len, max_hits);
   endtask

   function automatic logic [31:0] span_start_offset();
      if ($urandom_range(3) == 0)
         return 32'hFFFF_FFF0 + 32'($urandom_range(15));
      return $urandom;
   endfunction

   // Stream of scans and spans with the signature planted now and then
   task automatic scan_stream(input int unsigned count);
      logic [127:0] sig_bytes;
      logic [31:0]  offset;
      logic [7:0]   data;
      logic         span_first;
      logic         scan_first;
      int unsigned  plant_pos;
      bit           planting;
      sig_bytes  = {sig_high, sig_low};
      offset     = span_start_offset();
      span_first = 1'b1;
      scan_first = 1'b1;
      planting   = 0;
      plant_pos  = 0;
      for (int unsigned sent = 0; sent < count; sent++) begin
         if (!planting && sig_len != 0 && $urandom_range(3) == 0) begin
            planting  = 1;
            plant_pos = 0;
         end
         if (planting && plant_pos < sig_len && plant_pos < mbss_pkg::MAX_PATTERN_BYTES) begin
            data = sig_care[plant_pos] ? sig_bytes[plant_pos*8 +: 8] : 8'($urandom);
            // now and then a broken signature
            if ($urandom_range(19) == 0)
               data = 8'($urandom);
            plant_pos++;
            if (plant_pos >= sig_len)
               planting = 0;
         end else begin
            planting = 0;
            data = 8'($urandom);
         end
         send_byte(data, offset, span_first, scan_first);
         offset++;
         scan_first = ($urandom_range(49) == 0);
         span_first = scan_first || ($urandom_range(29) == 0);
         if (span_first && $urandom_range(1) == 0)
            offset = span_start_offset();
      end
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero length, so nothing hits
      send_byte(8'h00, 32'h0000_0000, 1'b1, 1'b1);
      send_byte(8'hFF, 32'h0000_0001, 1'b0, 1'b0);
      settle();

      // three bytes with a wildcard in the middle, zero limit acts as one
      program_scanner(64'h0000_0000_00C3_5AA5, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0005,
                      5'd3, 16'd0);
      send_byte(8'hA5, 32'hFFFF_FFFE, 1'b1, 1'b1);
      send_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_byte(8'hC3, 32'h0000_0000, 1'b0, 1'b0);   // hit, offset wraps back
      send_byte(8'hA5, 32'h0000_0001, 1'b0, 1'b0);
      send_byte(8'hFF, 32'h0000_0002, 1'b0, 1'b0);
      send_byte(8'hC3, 32'h0000_0003, 1'b0, 1'b0);   // limit already reached
      send_byte(8'hA5, 32'h0000_0100, 1'b1, 1'b1);
      send_byte(8'h00, 32'h0000_0200, 1'b1, 1'b0);   // new span: window cleared
      send_byte(8'hC3, 32'h0000_0201, 1'b0, 1'b0);   // span still too short
      send_byte(8'hC3, 32'h0000_0202, 1'b0, 1'b0);
      settle();

      // length beyond the window
      program_scanner(64'd0, 64'd0, 16'hFFFF, 5'd20, 16'd5);
      send_byte(8'h00, 32'h0000_1000, 1'b1, 1'b1);
      send_byte(8'h00, 32'h0000_1001, 1'b0, 1'b0);
      settle();

      // single wildcard byte, two hits allowed
      program_scanner(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'h0000, 5'd1, 16'd2);
      send_byte(8'hFF, 32'h8000_0000, 1'b1, 1'b1);
      send_byte(8'h00, 32'h8000_0001, 1'b0, 1'b0);
      send_byte(8'hFF, 32'h8000_0002, 1'b0, 1'b0);
      settle();

      // every byte hits while the sink holds off: the block backs up
      program_scanner(64'd0, 64'd0, 16'h0000, 5'd1, 16'hFFFF);
      tx_idle_pct = 0;
      holds_asked <= holds_asked + 1;
      scan_stream(60);
      settle();

      // random part under three idling regimes
      for (int regime = 0; regime < 3; regime++) begin
         tx_idle_pct = (regime == 0) ? 13 : (regime == 1) ? 68 : 0;
         rx_idle_pct = (regime == 0) ? 68 : (regime == 1) ? 13 : 0;
         for (int k = 0; k < 5; k++) begin
            settle();
            pick_setting(5 * regime + k);
            scan_stream(33);
         end
      end
      settle();

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
